@@ sv/csvg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package csvg_pkg;

    // Q2.30 unit value and the width of the configuration index.
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_COS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMIT_NORMALS = 2'd2;

    localparam logic signed [31:0] RST_STEP_COS = 32'sd1068232801;
    localparam logic signed [31:0] RST_STEP_SIN = 32'sd108628645;

    typedef struct packed {
        logic [31:0] center_x;
        logic [31:0] center_y;
        logic [30:0] radius;
    } t_circle;

    typedef struct packed {
        logic [31:0] step_cos;
        logic [31:0] step_sin;
        logic        emit_normals;
    } t_cfg;

    typedef struct packed {
        logic [31:0] vertex_x;
        logic [31:0] vertex_y;
        logic [31:0] normal_x;
        logic [31:0] normal_y;
        logic        last_vertex;
    } t_vertex;

endpackage

`default_nettype wire

@@ sv/csvg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface csvg_circle_if;
    logic        valid;
    logic        ready;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [30:0] radius;

    modport source (output valid, output center_x, output center_y, output radius,
                    input ready);
    modport sink (input valid, input center_x, input center_y, input radius,
                  output ready);
endinterface

interface csvg_vertex_if;
    logic        valid;
    logic        ready;
    logic [31:0] vertex_x;
    logic [31:0] vertex_y;
    logic [31:0] normal_x;
    logic [31:0] normal_y;
    logic        last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output normal_x,
                    output normal_y, output last_vertex, input ready);
    modport sink (input valid, input vertex_x, input vertex_y, input normal_x,
                  input normal_y, input last_vertex, output ready);
endinterface

interface csvg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [csvg_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/circle_strip_vertex_generator.sv @@
// A circle's first vertex passes the circle queue, slot and circle registers, multiply
// stage and output register. One vertex per cycle while output is not stalled, set by
// the single output register; VERTEX_SLOTS vertices per circle, no gap between circles.
// A two-entry circle queue lets the input side keep transferring while output stalls.
// Reset (synchronous, active low) empties the queue and pipeline and restores the
// step and normal-enable registers to their defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module circle_strip_vertex_generator #(
    parameter int unsigned VERTEX_SLOTS = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    csvg_circle_if.sink   i_circle,
    csvg_cfg_if.sink      i_cfg,
    csvg_vertex_if.source o_vertex
);

    csvg_pkg::t_cfg    r_cfg;
    csvg_pkg::t_circle head;
    csvg_pkg::t_vertex vertex;
    logic              head_valid;
    logic              pop;
    logic              vertex_valid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_cos     <= csvg_pkg::RST_STEP_COS;
            r_cfg.step_sin     <= csvg_pkg::RST_STEP_SIN;
            r_cfg.emit_normals <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                csvg_pkg::REG_STEP_COS:     r_cfg.step_cos     <= i_cfg.data;
                csvg_pkg::REG_STEP_SIN:     r_cfg.step_sin     <= i_cfg.data;
                csvg_pkg::REG_EMIT_NORMALS: r_cfg.emit_normals <= i_cfg.data[0];
                default:                    r_cfg              <= r_cfg;
            endcase
        end
    end

    csvg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_circle     (i_circle),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    csvg_back #(
        .VERTEX_SLOTS (VERTEX_SLOTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (head),
        .i_head_valid   (head_valid),
        .o_pop          (pop),
        .o_vertex       (vertex),
        .o_vertex_valid (vertex_valid),
        .i_vertex_ready (o_vertex.ready)
    );

    assign o_vertex.valid       = vertex_valid;
    assign o_vertex.vertex_x    = vertex.vertex_x;
    assign o_vertex.vertex_y    = vertex.vertex_y;
    assign o_vertex.normal_x    = vertex.normal_x;
    assign o_vertex.normal_y    = vertex.normal_y;
    assign o_vertex.last_vertex = vertex.last_vertex;

endmodule

`default_nettype wire

@@ sv/csvg_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Takes circles from the input channel into a two-entry queue that feeds the
// vertex sequencer.
module csvg_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    csvg_circle_if.sink        i_circle,
    output csvg_pkg::t_circle  o_head,
    output logic               o_head_valid,
    input  wire logic          i_pop
);

    csvg_pkg::t_circle r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign i_circle.ready = (r_count != 2'd2);
    assign push           = i_circle.valid && i_circle.ready;
    assign o_head_valid   = (r_count != 2'd0);
    assign pop            = i_pop && o_head_valid;
    assign o_head         = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{center_x: i_circle.center_x,
                             center_y: i_circle.center_y,
                             radius:   i_circle.radius};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/csvg_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Vertex sequencer: one slot issued per cycle unless the output stalls, a multiply
// stage, and a round/add/saturate stage into the output register. The direction is
// rotated once per vertex pair: products at the even slot, update at the odd slot.
module csvg_back #(
    parameter int unsigned VERTEX_SLOTS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire csvg_pkg::t_cfg     i_cfg,
    input  wire csvg_pkg::t_circle  i_head,
    input  wire logic               i_head_valid,
    output logic                    o_pop,
    output csvg_pkg::t_vertex       o_vertex,
    output logic                    o_vertex_valid,
    input  wire logic               i_vertex_ready
);

    localparam int unsigned SW = $clog2(VERTEX_SLOTS);

    logic              en;
    logic              load;
    logic              last_slot;
    logic              mirror;

    logic              r_busy;
    logic [SW-1:0]     r_slot;
    logic [31:0]       r_cx;
    logic [31:0]       r_cy;
    logic [30:0]       r_rad;
    logic signed [31:0] r_dx;
    logic signed [31:0] r_dy;
    logic signed [63:0] r_pxc;
    logic signed [63:0] r_pys;
    logic signed [63:0] r_pxs;
    logic signed [63:0] r_pyc;

    logic signed [31:0] n_dx;
    logic signed [31:0] n_dy;

    logic               r_s1_valid;
    logic               r_s1_mirror;
    logic               r_s1_last;
    logic [31:0]        r_s1_cx;
    logic [31:0]        r_s1_cy;
    logic [31:0]        r_s1_dx;
    logic [31:0]        r_s1_dy;
    logic signed [63:0] r_s1_prx;
    logic signed [63:0] r_s1_pry;

    logic               r_out_valid;
    csvg_pkg::t_vertex  r_out;
    csvg_pkg::t_vertex  n_out;

    function automatic logic [31:0] clamp_unit(input logic [65:0] sum);
        logic [35:0] rnd;
        rnd = sum[65:30] + {35'd0, sum[29]};
        if ($signed(rnd) > 36'sd1073741824) begin
            return csvg_pkg::ONE_Q30;
        end else if ($signed(rnd) < -36'sd1073741824) begin
            return -csvg_pkg::ONE_Q30;
        end
        return rnd[31:0];
    endfunction

    function automatic logic [31:0] sat32(input logic [33:0] sum);
        if ($signed(sum) > 34'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if ($signed(sum) < -34'sd2147483648) begin
            return 32'h8000_0000;
        end
        return sum[31:0];
    endfunction

    assign en        = !r_out_valid || i_vertex_ready;
    assign last_slot = (r_slot == SW'(VERTEX_SLOTS - 1));
    assign mirror    = r_slot[0];
    assign o_pop     = !r_busy || (en && last_slot);
    assign load      = o_pop && i_head_valid;

    // Rotated direction from the products taken at the preceding even slot.
    always_comb begin
        logic [65:0] sx;
        logic [65:0] sy;
        sx   = {{2{r_pxc[63]}}, r_pxc} - {{2{r_pys[63]}}, r_pys};
        sy   = {{2{r_pxs[63]}}, r_pxs} + {{2{r_pyc[63]}}, r_pyc};
        n_dx = clamp_unit(sx);
        n_dy = clamp_unit(sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= '0;
            r_dx   <= csvg_pkg::ONE_Q30;
            r_dy   <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_slot <= '0;
            r_dx   <= csvg_pkg::ONE_Q30;
            r_dy   <= '0;
        end else if (r_busy && en) begin
            r_slot <= r_slot + SW'(1);
            if (last_slot) begin
                r_busy <= 1'b0;
            end
            if (mirror) begin
                r_dx <= n_dx;
                r_dy <= n_dy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cx  <= i_head.center_x;
            r_cy  <= i_head.center_y;
            r_rad <= i_head.radius;
        end
        if (r_busy && en && !mirror) begin
            r_pxc <= r_dx * $signed(i_cfg.step_cos);
            r_pys <= r_dy * $signed(i_cfg.step_sin);
            r_pxs <= r_dx * $signed(i_cfg.step_sin);
            r_pyc <= r_dy * $signed(i_cfg.step_cos);
        end
    end

    // Multiply stage: offsets of this slot before rounding.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_mirror <= mirror;
            r_s1_last   <= last_slot;
            r_s1_cx     <= r_cx;
            r_s1_cy     <= r_cy;
            r_s1_dx     <= r_dx;
            r_s1_dy     <= r_dy;
            r_s1_prx    <= r_dx * $signed({1'b0, r_rad});
            r_s1_pry    <= r_dy * $signed({1'b0, r_rad});
        end
    end

    always_comb begin
        logic [33:0] offx;
        logic [33:0] offy;
        logic [33:0] cx;
        logic [33:0] cy;
        offx = r_s1_prx[63:30] + {33'd0, r_s1_prx[29]};
        offy = r_s1_pry[63:30] + {33'd0, r_s1_pry[29]};
        cx   = {{2{r_s1_cx[31]}}, r_s1_cx};
        cy   = {{2{r_s1_cy[31]}}, r_s1_cy};
        n_out.vertex_x    = sat32(cx + offx);
        n_out.vertex_y    = r_s1_mirror ? sat32(cy - offy) : sat32(cy + offy);
        n_out.normal_x    = i_cfg.emit_normals ? r_s1_dx : 32'd0;
        n_out.normal_y    = !i_cfg.emit_normals ? 32'd0 :
                            (r_s1_mirror ? (32'd0 - r_s1_dy) : r_s1_dy);
        n_out.last_vertex = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_vertex       = r_out;
    assign o_vertex_valid = r_out_valid;

endmodule

`default_nettype wire
